### src/spsc_pkg.sv
// shared types and constants for the stream pattern skip/clip block
// no dependencies

package spsc_pkg;

   localparam int MAX_PATTERN = 8;
   localparam int IDX_W       = $clog2(MAX_PATTERN);
   localparam int FILL_W      = $clog2(MAX_PATTERN + 1);
   localparam int QDEPTH      = 2;
   localparam int QPTR_W      = $clog2(QDEPTH);
   localparam int QCNT_W      = $clog2(QDEPTH + 1);

   localparam logic [1:0] KIND_DATA     = 2'd0;
   localparam logic [1:0] KIND_FOUND    = 2'd1;
   localparam logic [1:0] KIND_NOTFOUND = 2'd2;

   localparam logic [1:0] CSR_CLIP_MODE = 2'd0;
   localparam logic [1:0] CSR_PATTERN   = 2'd1;
   localparam logic [1:0] CSR_LENGTH    = 2'd2;

   localparam logic ACTION_DATA = 1'b0;
   localparam logic ACTION_EOS  = 1'b1;

   typedef logic [MAX_PATTERN-1:0][7:0] window_type;

   typedef struct packed {
      window_type        wnd;
      logic [IDX_W-1:0]  hi;
      logic [FILL_W-1:0] count;
      logic              term;
      logic [1:0]        term_kind;
   } job_type;

   typedef struct packed {
      logic              full;
      logic [QCNT_W-1:0] count;
   } qstat_type;

endpackage

### src/spsc_front.sv
// front end: config registers, sliding window, match and job building
// depends on spsc_pkg

module spsc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wen,
   input  logic [1:0]           csr_index,
   input  logic [63:0]          csr_wdata,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,
   input  logic                 req_tuser,
   input  spsc_pkg::qstat_type  q_stat,
   output logic                 push,
   output spsc_pkg::job_type    push_job
);

   logic                            clip_ff;
   logic [63:0]                     pat_ff;
   logic [3:0]                      len_cfg_ff;
   spsc_pkg::window_type            wnd_ff, wnd_in;
   logic [spsc_pkg::FILL_W-1:0]     fill_ff, fill_in;
   logic [spsc_pkg::FILL_W-1:0]     len_eff;
   logic [spsc_pkg::IDX_W-1:0]      len_m1;
   logic [spsc_pkg::FILL_W-1:0]     fill_mid;
   logic [spsc_pkg::FILL_W-1:0]     fill_m1;
   logic                            match;
   logic                            accept;
   logic [spsc_pkg::IDX_W-1:0]      sel;

   assign req_tready = !q_stat.full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      if (len_cfg_ff == '0) begin
         len_eff = spsc_pkg::FILL_W'(1);
      end else if (len_cfg_ff > 4'(spsc_pkg::MAX_PATTERN)) begin
         len_eff = spsc_pkg::FILL_W'(spsc_pkg::MAX_PATTERN);
      end else begin
         len_eff = spsc_pkg::FILL_W'(len_cfg_ff);
      end
   end

   assign len_m1  = spsc_pkg::IDX_W'(len_eff - spsc_pkg::FILL_W'(1));
   assign fill_m1 = fill_ff - spsc_pkg::FILL_W'(1);

   always_comb begin
      wnd_in = {wnd_ff[spsc_pkg::MAX_PATTERN-2:0], req_tdata};
      fill_mid = (fill_ff >= len_eff) ? len_eff : fill_ff + spsc_pkg::FILL_W'(1);
      match = (fill_mid == len_eff);
      for (int i = 0; i < spsc_pkg::MAX_PATTERN; i++) begin
         sel = len_m1 - spsc_pkg::IDX_W'(i);
         if (spsc_pkg::FILL_W'(i) < len_eff && wnd_in[sel] != pat_ff[8*i +: 8]) begin
            match = 1'b0;
         end
      end
   end

   always_comb begin
      push_job.wnd       = wnd_ff;
      push_job.hi        = spsc_pkg::IDX_W'(fill_m1);
      push_job.count     = '0;
      push_job.term      = 1'b0;
      push_job.term_kind = spsc_pkg::KIND_NOTFOUND;
      fill_in            = fill_ff;
      if (req_tuser == spsc_pkg::ACTION_EOS) begin
         if (clip_ff) begin
            push_job.count = fill_ff;
         end
         push_job.term = 1'b1;
         fill_in       = '0;
      end else begin
         if (clip_ff && fill_ff >= len_eff) begin
            push_job.count = fill_ff - len_eff + spsc_pkg::FILL_W'(1);
         end
         if (match) begin
            push_job.term      = 1'b1;
            push_job.term_kind = spsc_pkg::KIND_FOUND;
            fill_in            = '0;
         end else begin
            fill_in = fill_mid;
         end
      end
   end

   assign push = accept && (push_job.term || push_job.count != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_ff    <= 1'b0;
         pat_ff     <= '0;
         len_cfg_ff <= 4'd1;
         fill_ff    <= '0;
      end else begin
         if (csr_wen) begin
            case (csr_index)
               spsc_pkg::CSR_CLIP_MODE: clip_ff    <= csr_wdata[0];
               spsc_pkg::CSR_PATTERN:   pat_ff     <= csr_wdata;
               spsc_pkg::CSR_LENGTH:    len_cfg_ff <= csr_wdata[3:0];
               default: ;
            endcase
         end
         if (accept) begin
            fill_ff <= fill_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_tuser == spsc_pkg::ACTION_DATA) begin
         wnd_ff <= wnd_in;
      end
   end

endmodule

### src/spsc_queue.sv
// short job queue between front and back
// depends on spsc_pkg

module spsc_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  spsc_pkg::job_type    push_job,
   input  logic                 pop,
   output logic                 head_valid,
   output spsc_pkg::job_type    head_job,
   output spsc_pkg::qstat_type  q_stat
);

   spsc_pkg::job_type               mem_ff [spsc_pkg::QDEPTH];
   logic [spsc_pkg::QPTR_W-1:0]     wr_ff, rd_ff;
   logic [spsc_pkg::QCNT_W-1:0]     cnt_ff;
   logic                            do_pop;

   assign head_valid   = (cnt_ff != '0);
   assign head_job     = mem_ff[rd_ff];
   assign do_pop       = pop && head_valid;
   assign q_stat.full  = (cnt_ff == spsc_pkg::QCNT_W'(spsc_pkg::QDEPTH));
   assign q_stat.count = cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == spsc_pkg::QPTR_W'(spsc_pkg::QDEPTH - 1)) ? '0
                     : wr_ff + spsc_pkg::QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == spsc_pkg::QPTR_W'(spsc_pkg::QDEPTH - 1)) ? '0
                     : rd_ff + spsc_pkg::QPTR_W'(1);
         end
         if (push && !do_pop) begin
            cnt_ff <= cnt_ff + spsc_pkg::QCNT_W'(1);
         end else if (!push && do_pop) begin
            cnt_ff <= cnt_ff - spsc_pkg::QCNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_job;
      end
   end

endmodule

### src/spsc_back.sv
// back end: walks one job into result items, one a cycle while the output is not stalled, through the output register
// depends on spsc_pkg

module spsc_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  spsc_pkg::job_type  head_job,
   output logic               pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,
   output logic [1:0]         rsp_tuser,
   output logic               rsp_tlast
);

   logic                          out_valid_ff, out_valid_in;
   logic [7:0]                    out_byte_ff;
   logic [1:0]                    out_kind_ff;
   logic                          out_last_ff;
   logic [spsc_pkg::FILL_W-1:0]   k_ff, k_in;
   logic                          produce;
   logic                          is_data;
   logic                          final_one;
   logic [spsc_pkg::IDX_W-1:0]    idx;

   assign produce = head_valid && (!out_valid_ff || rsp_tready);
   assign is_data = (k_ff < head_job.count);
   assign idx     = head_job.hi - spsc_pkg::IDX_W'(k_ff);

   always_comb begin
      if (is_data) begin
         final_one = !head_job.term && (k_ff + spsc_pkg::FILL_W'(1) == head_job.count);
      end else begin
         final_one = 1'b1;
      end
   end

   assign pop  = produce && final_one;
   assign k_in = pop ? '0 : k_ff + spsc_pkg::FILL_W'(1);

   always_comb begin
      if (produce) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         k_ff         <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (produce) begin
            k_ff <= k_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (produce) begin
         if (is_data) begin
            out_byte_ff <= head_job.wnd[idx];
            out_kind_ff <= spsc_pkg::KIND_DATA;
            out_last_ff <= 1'b0;
         end else begin
            out_byte_ff <= '0;
            out_kind_ff <= head_job.term_kind;
            out_last_ff <= 1'b1;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

### src/stream_pattern_skip_clip.sv
// top level of the stream pattern skip/clip block
// an accepted request's results pass through the job queue and the output register
// throughput: one request per cycle while output is not stalled and each request
//   gives at most one result; a request with n results (up to 9) holds the back end
// reset: synchronous; clears the search, queue and output valid, config to defaults
// depends on spsc_pkg, spsc_front, spsc_queue, spsc_back

module stream_pattern_skip_clip (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wen,
   input  logic [1:0]   csr_index,
   input  logic [63:0]  csr_wdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // data_byte
   input  logic         req_tuser,   // action
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,   // out_byte
   output logic [1:0]   rsp_tuser,   // kind
   output logic         rsp_tlast
);

   logic                 push;
   spsc_pkg::job_type    push_job;
   logic                 pop;
   logic                 head_valid;
   spsc_pkg::job_type    head_job;
   spsc_pkg::qstat_type  q_stat;

   spsc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_stat     (q_stat),
      .push       (push),
      .push_job   (push_job)
   );

   spsc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job),
      .q_stat     (q_stat)
   );

   spsc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser != spsc_pkg::KIND_DATA)))
      else $error("last flag does not match result kind");

   a_term_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != spsc_pkg::KIND_DATA) |-> (rsp_tdata == '0))
      else $error("terminal result carries nonzero byte");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      (q_stat.full |-> !push) and
      (q_stat.count <= spsc_pkg::QCNT_W'(spsc_pkg::QDEPTH)))
      else $error("job queue overflow");

endmodule
